/* design/sawarq_pkg.sv */
// shared types and constants for the stop-and-wait arq sender
package sawarq_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic [2:0]  mode;
		logic        reply_syn;
		logic        reply_ack;
		logic        reply_nak;
		logic [15:0] payload_word;
		logic        chunk_end;
	} item_t;

	typedef struct packed {
		logic [2:0]  frame_kind;
		logic        seq_bit;
		logic [15:0] frame_checksum;
		logic [3:0]  status;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [11:0] connect_timeout_ticks;
		logic [11:0] data_timeout_ticks;
		logic [11:0] close_timeout_ticks;
		logic [2:0]  max_nak_retries;
	} cfg_t;

	// input modes
	localparam logic [2:0] MODE_OPEN  = 3'd0;
	localparam logic [2:0] MODE_REPLY = 3'd1;
	localparam logic [2:0] MODE_TICK  = 3'd2;
	localparam logic [2:0] MODE_DATA  = 3'd3;
	localparam logic [2:0] MODE_EOF   = 3'd4;

	// frame kinds
	localparam logic [2:0] FK_NONE  = 3'd0;
	localparam logic [2:0] FK_SYN   = 3'd1;
	localparam logic [2:0] FK_ACK   = 3'd2;
	localparam logic [2:0] FK_BEGIN = 3'd3;
	localparam logic [2:0] FK_DATA  = 3'd4;
	localparam logic [2:0] FK_END   = 3'd5;
	localparam logic [2:0] FK_FIN   = 3'd6;

	// status codes
	localparam logic [3:0] ST_NONE        = 4'd0;
	localparam logic [3:0] ST_CONNECTED   = 4'd1;
	localparam logic [3:0] ST_CONN_FAILED = 4'd2;
	localparam logic [3:0] ST_DELIVERED   = 4'd3;
	localparam logic [3:0] ST_DROPPED     = 4'd4;
	localparam logic [3:0] ST_RESENT      = 4'd5;
	localparam logic [3:0] ST_CLOSED      = 4'd6;
	localparam logic [3:0] ST_CLOSE_TO    = 4'd7;
	localparam logic [3:0] ST_IGNORED     = 4'd8;

	// register indexes
	localparam logic [1:0] REG_CONNECT_TO = 2'd0;
	localparam logic [1:0] REG_DATA_TO    = 2'd1;
	localparam logic [1:0] REG_CLOSE_TO   = 2'd2;
	localparam logic [1:0] REG_MAX_NAK    = 2'd3;

	localparam logic [11:0] CONNECT_TO_RST = 12'd3000;
	localparam logic [11:0] DATA_TO_RST    = 12'd50;
	localparam logic [11:0] CLOSE_TO_RST   = 12'd2000;
	localparam logic [2:0]  MAX_NAK_RST    = 3'd2;

	localparam logic [11:0] TIMER_MAX = 12'hFFF;

endpackage

/* design/stop_and_wait_arq_sender.sv */
// Stop-and-wait arq sender: connection setup, chunk checksum, resend and close.
// Input channel (item_valid/item_ready/item) carries one event per transaction:
// open, peer reply, tick, payload word, end of file or idle. Output channel
// (result_valid/result_ready/result) carries one frame or status per
// transaction; run_last marks the last result caused by an input event.
// An event produces zero, one or two results.
// An accepted event waits in the input register; its results are registered in
// the result register when it moves on. Throughput: one event per cycle while
// each event gives at most one result and the receiver keeps up; an event with
// two results holds the result register for two output transactions, set by the
// two-entry result register. When the receiver stalls, one more event is taken
// into the input register and item_ready then drops until the result register
// drains. Reset puts the link in the disconnected phase with sequence bit 1,
// clears the checksum, counters and timer, and loads the default timeouts.
// Configuration is written over the apb port; the user must do so only while no
// event is in flight, as the block itself does not enforce it.
module stop_and_wait_arq_sender #(
	parameter int unsigned WORDS_PER_CHUNK = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  sawarq_pkg::item_t                 item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output sawarq_pkg::result_t               result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sawarq_pkg::ADDR_W-1:0]     paddr,
	input  logic [sawarq_pkg::DATA_W-1:0]     pwdata,
	output logic [sawarq_pkg::DATA_W-1:0]     prdata,
	output logic                              pready
);
	import sawarq_pkg::*;

	typedef enum logic [2:0] {
		PH_DISC = 3'd0,
		PH_WSYN = 3'd1,
		PH_CONN = 3'd2,
		PH_WDAT = 3'd3,
		PH_WFIN = 3'd4
	} phase_t;

	localparam logic [7:0] CHUNK_WORDS = 8'(WORDS_PER_CHUNK);

	cfg_t cfg;

	sawarq_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	item_t item_s1;
	logic  valid_s1;
	logic  s1_move;

	// link state
	phase_t      phase_q, phase_d;
	logic        seq_q, seq_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] held_q, held_d;
	logic [7:0]  words_q, words_d;
	logic [2:0]  nak_q, nak_d;
	logic [11:0] wait_q, wait_d;

	// result register, up to two entries
	result_t    res0_q, res1_q;
	logic [1:0] res_cnt_q;
	result_t    res0, res1;
	logic [1:0] res_n;

	logic [16:0] sum17;
	logic [15:0] sum_add;
	logic [7:0]  words_inc;
	logic [3:0]  nak_inc;
	logic [11:0] timer_inc;

	assign result_valid = (res_cnt_q != 2'd0);
	assign result       = res0_q;
	// the result register takes new results once it is empty or handing out its last one
	assign s1_move    = valid_s1 &&
		((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && result_ready));
	assign item_ready = !valid_s1 || s1_move;

	assign sum17     = {1'b0, sum_q} + {1'b0, item_s1.payload_word};
	// end-around carry
	assign sum_add   = sum17[16] ? (sum17[15:0] + 16'd1) : sum17[15:0];
	assign words_inc = words_q + 8'd1;
	assign nak_inc   = {1'b0, nak_q} + 4'd1;
	assign timer_inc = (wait_q != TIMER_MAX) ? (wait_q + 12'd1) : wait_q;

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		sum_d   = sum_q;
		held_d  = held_q;
		words_d = words_q;
		nak_d   = nak_q;
		wait_d  = wait_q;
		res0    = '0;
		res1    = '0;
		res_n   = 2'd0;
		if (valid_s1) begin
			case (item_s1.mode)
				MODE_OPEN: begin
					if (phase_q == PH_DISC) begin
						phase_d         = PH_WSYN;
						wait_d          = '0;
						res0.frame_kind = FK_SYN;
					end else begin
						res0.status = ST_IGNORED;
					end
					res_n = 2'd1;
				end
				MODE_REPLY: begin
					res_n = 2'd1;
					unique case (phase_q)
						PH_WSYN: begin
							if (item_s1.reply_syn && item_s1.reply_ack) begin
								res0.frame_kind = FK_ACK;
								res0.status     = ST_CONNECTED;
								res1.frame_kind = FK_BEGIN;
								res_n           = 2'd2;
								phase_d         = PH_CONN;
								seq_d           = 1'b1;
								sum_d           = '0;
								words_d         = '0;
							end else begin
								phase_d     = PH_DISC;
								res0.status = ST_CONN_FAILED;
							end
						end
						PH_WDAT: begin
							if (item_s1.reply_ack) begin
								seq_d       = ~seq_q;
								phase_d     = PH_CONN;
								res0.status = ST_DELIVERED;
							end else if (item_s1.reply_nak &&
									(nak_inc > {1'b0, cfg.max_nak_retries})) begin
								nak_d       = nak_inc[2:0];
								phase_d     = PH_CONN;
								res0.status = ST_DROPPED;
							end else begin
								// nak within the limit, or a reply with neither flag
								if (item_s1.reply_nak) begin
									nak_d = nak_inc[2:0];
								end
								wait_d              = '0;
								res0.frame_kind     = FK_DATA;
								res0.seq_bit        = seq_q;
								res0.frame_checksum = held_q;
								res0.status         = ST_RESENT;
							end
						end
						PH_WFIN: begin
							phase_d     = PH_DISC;
							res0.status = item_s1.reply_ack ? ST_CLOSED : ST_CLOSE_TO;
						end
						default: res0.status = ST_IGNORED;
					endcase
				end
				MODE_TICK: begin
					unique case (phase_q)
						PH_WSYN: begin
							wait_d = timer_inc;
							if (timer_inc >= cfg.connect_timeout_ticks) begin
								phase_d     = PH_DISC;
								res0.status = ST_CONN_FAILED;
								res_n       = 2'd1;
							end
						end
						PH_WDAT: begin
							wait_d = timer_inc;
							if (timer_inc >= cfg.data_timeout_ticks) begin
								wait_d              = '0;
								res0.frame_kind     = FK_DATA;
								res0.seq_bit        = seq_q;
								res0.frame_checksum = held_q;
								res0.status         = ST_RESENT;
								res_n               = 2'd1;
							end
						end
						PH_WFIN: begin
							wait_d = timer_inc;
							if (timer_inc >= cfg.close_timeout_ticks) begin
								phase_d     = PH_DISC;
								res0.status = ST_CLOSE_TO;
								res_n       = 2'd1;
							end
						end
						default: ;
					endcase
				end
				MODE_DATA: begin
					if (phase_q == PH_CONN) begin
						sum_d   = sum_add;
						words_d = words_inc;
						if (item_s1.chunk_end || (words_inc >= CHUNK_WORDS)) begin
							held_d              = ~sum_add;
							sum_d               = '0;
							words_d             = '0;
							nak_d               = '0;
							phase_d             = PH_WDAT;
							wait_d              = '0;
							res0.frame_kind     = FK_DATA;
							res0.seq_bit        = seq_q;
							res0.frame_checksum = ~sum_add;
							res_n               = 2'd1;
						end
					end else begin
						res0.status = ST_IGNORED;
						res_n       = 2'd1;
					end
				end
				MODE_EOF: begin
					if (phase_q == PH_CONN) begin
						// a partial chunk is thrown away
						sum_d           = '0;
						words_d         = '0;
						phase_d         = PH_WFIN;
						wait_d          = '0;
						res0.frame_kind = FK_END;
						res1.frame_kind = FK_FIN;
						res_n           = 2'd2;
					end else begin
						res0.status = ST_IGNORED;
						res_n       = 2'd1;
					end
				end
				default: ;
			endcase
		end
		res0.run_last = (res_n == 2'd1);
		res1.run_last = 1'b1;
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// link state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISC;
			seq_q   <= 1'b1;
			sum_q   <= '0;
			held_q  <= '0;
			words_q <= '0;
			nak_q   <= '0;
			wait_q  <= '0;
		end else if (s1_move) begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			sum_q   <= sum_d;
			held_q  <= held_d;
			words_q <= words_d;
			nak_q   <= nak_d;
			wait_q  <= wait_d;
		end
	end

	// result register fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (s1_move) begin
			res_cnt_q <= res_n;
		end else if (result_valid && result_ready) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res0_q <= res0;
			res1_q <= res1;
		end else if (result_valid && result_ready) begin
			res0_q <= res1_q;
		end
	end

`ifndef ASSERT_OFF
	a_res_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result register holds more than two entries");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && (res_cnt_q != 2'd0)))
		else $error("input stalled with nothing pending");

	a_delivered_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (res0.status == ST_DELIVERED)) |=> (seq_q != $past(seq_q)))
		else $error("delivered chunk did not toggle the sequence bit");

	a_data_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (res0.frame_kind == FK_DATA)) |=>
			((phase_q == PH_WDAT) && (wait_q == 12'd0)))
		else $error("data frame sent without waiting for a reply");

	a_two_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (res_cnt_q == 2'd2)) |-> !result.run_last)
		else $error("first of two results marked last");
`endif

endmodule

/* design/sawarq_cfg_regs.sv */
// apb configuration registers: timeouts and nak retry limit
module sawarq_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sawarq_pkg::ADDR_W-1:0]     paddr,
	input  logic [sawarq_pkg::DATA_W-1:0]     pwdata,
	output logic [sawarq_pkg::DATA_W-1:0]     prdata,
	output logic                              pready,
	output sawarq_pkg::cfg_t                  cfg
);
	import sawarq_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout_ticks <= CONNECT_TO_RST;
			cfg_q.data_timeout_ticks    <= DATA_TO_RST;
			cfg_q.close_timeout_ticks   <= CLOSE_TO_RST;
			cfg_q.max_nak_retries       <= MAX_NAK_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CONNECT_TO: cfg_q.connect_timeout_ticks <= pwdata[11:0];
				REG_DATA_TO:    cfg_q.data_timeout_ticks    <= pwdata[11:0];
				REG_CLOSE_TO:   cfg_q.close_timeout_ticks   <= pwdata[11:0];
				REG_MAX_NAK:    cfg_q.max_nak_retries       <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CONNECT_TO: prdata = {20'd0, cfg_q.connect_timeout_ticks};
			REG_DATA_TO:    prdata = {20'd0, cfg_q.data_timeout_ticks};
			REG_CLOSE_TO:   prdata = {20'd0, cfg_q.close_timeout_ticks};
			REG_MAX_NAK:    prdata = {29'd0, cfg_q.max_nak_retries};
			default:        prdata = '0;
		endcase
	end

endmodule
